@@ rtl/cdda_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar date day arithmetic package
// Shared types, constants and date helper functions.
// ----------------------------------------------------------------------------
package cdda_pkg;

  localparam int DvdW = 28;
  localparam int DsrW = 21;
  localparam int RcpW = 26;
  localparam int CntW = 2;

  // Divider phases, counted down from the start.
  localparam logic [CntW-1:0] PhRecip = CntW'(3);
  localparam logic [CntW-1:0] PhBack  = CntW'(2);
  localparam logic [CntW-1:0] PhFix   = CntW'(1);

  localparam logic [1:0] CfgMonth = 2'd0;
  localparam logic [1:0] CfgDay   = 2'd1;
  localparam logic [1:0] CfgYear  = 2'd2;

  localparam logic [3:0]  RstMonth = 4'd5;
  localparam logic [4:0]  RstDay   = 5'd11;
  localparam logic [13:0] RstYear  = 14'd1959;

  localparam logic signed [25:0] JdFirst = 26'sd1721426;
  localparam logic signed [25:0] JdLast  = 26'sd5373484;

  typedef enum logic [4:0] {
    ST_IDLE, ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
    ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_OUT
  } step_e;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DsrW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic [DvdW-1:0] quot;
    logic [DsrW-1:0] rem;
  } div_rsp_t;

  // Floor of 2^DvdW over each divisor the date steps use. With a dividend
  // below 2^DvdW the product estimate is low by at most one.
  function automatic logic [RcpW-1:0] recip(input logic [DsrW-1:0] d);
    logic [RcpW-1:0] r;
    case (d)
      21'd7:       r = 26'd38347922;
      21'd80:      r = 26'd3355443;
      21'd100:     r = 26'd2684354;
      21'd2447:    r = 26'd109699;
      21'd146097:  r = 26'd1837;
      21'd1461001: r = 26'd183;
      default:     r = '0;
    endcase
    return r;
  endfunction

  // 367*(m-2-12a)/12 for every 4-bit month code.
  function automatic logic [8:0] month_term(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd305;
      4'd1:    r = 9'd336;
      4'd2:    r = 9'd367;
      4'd3:    r = 9'd30;
      4'd4:    r = 9'd61;
      4'd5:    r = 9'd91;
      4'd6:    r = 9'd122;
      4'd7:    r = 9'd152;
      4'd8:    r = 9'd183;
      4'd9:    r = 9'd214;
      4'd10:   r = 9'd244;
      4'd11:   r = 9'd275;
      4'd12:   r = 9'd305;
      4'd13:   r = 9'd336;
      4'd14:   r = 9'd367;
      default: r = 9'd397;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Year plus 4900, minus one for January and February (and month zero).
  function automatic logic [14:0] century_arg(input logic [3:0] m, input logic [13:0] y);
    return 15'(y) + 15'd4900 - ((m <= 4'd2) ? 15'd1 : 15'd0);
  endfunction

  // Julian day number, given the century quotient from the divider.
  function automatic logic [23:0] jd_calc(input logic [3:0] m, input logic [4:0] d,
                                          input logic [13:0] y, input logic [14:0] q);
    logic [14:0] ya;
    logic [25:0] prod;
    logic [25:0] sum;
    ya   = 15'(y) + 15'd4800 - ((m <= 4'd2) ? 15'd1 : 15'd0);
    prod = 26'(ya) * 26'd1461;
    sum  = 26'(d) + (prod >> 2) + 26'(month_term(m)) - 26'd32075
         - ((26'(q) * 26'd3) >> 2);
    return sum[23:0];
  endfunction

endpackage

@@ rtl/cdda_div.sv @@
// ----------------------------------------------------------------------------
// Constant divider
// Unsigned division by one of the fixed date divisors, shared by all date
// steps: a reciprocal multiply, a back multiply and one correction step.
// ----------------------------------------------------------------------------
module cdda_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cdda_pkg::div_req_t  req_i,
  output cdda_pkg::div_rsp_t  rsp_o
);
  import cdda_pkg::*;

  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DvdW-1:0]      dvd_q, dvd_d;
  logic [DsrW-1:0]      dsr_q, dsr_d;
  logic [DvdW-1:0]      quot_q, quot_d;
  logic [DsrW:0]        rem_q, rem_d;
  logic [DvdW-1:0]      mul_a;
  logic [RcpW-1:0]      mul_b;
  logic [DvdW+RcpW-1:0] prod;

  // One multiplier serves both the quotient estimate and the back product.
  assign mul_a = (cnt_q == PhRecip) ? dvd_q : quot_q;
  assign mul_b = (cnt_q == PhRecip) ? recip(dsr_q) : RcpW'(dsr_q);
  assign prod  = (DvdW+RcpW)'(mul_a) * (DvdW+RcpW)'(mul_b);

  always_comb begin
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      cnt_d = PhRecip;
      dvd_d = req_i.dividend;
      dsr_d = req_i.divisor;
    end else begin
      case (cnt_q)
        PhRecip: begin
          quot_d = DvdW'(prod >> DvdW);
          cnt_d  = PhBack;
        end
        PhBack: begin
          // The estimate is at most one low, so this is below twice the divisor.
          rem_d = (DsrW+1)'(dvd_q - prod[DvdW-1:0]);
          cnt_d = PhFix;
        end
        PhFix: begin
          if (rem_q >= {1'b0, dsr_q}) begin
            quot_d = quot_q + 1'b1;
            rem_d  = rem_q - {1'b0, dsr_q};
          end
          cnt_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dsr_q  <= dsr_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.busy = cnt_q != '0;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q[DsrW-1:0];

endmodule

@@ rtl/calendar_date_day_arithmetic.sv @@
// ----------------------------------------------------------------------------
// Calendar date day arithmetic
// Keeps a Gregorian date, shifts it by a day offset through Julian day
// numbers and reports day number, day of year, weekday and a day distance.
// ----------------------------------------------------------------------------
//  channel  signals                          direction
//  in       in_valid_i / in_ready_o          item in (mode, date, offset, compare)
//  out      out_valid_o / out_ready_i        result out
//  cfg      cfg_valid_i / cfg_ready_o        default date register write
//
//  Every division runs through one shared reciprocal divider. The result
//  stays on the outputs until its transfer; a new item is taken only after
//  that. Reset loads the default date 5/11/1959.
// ----------------------------------------------------------------------------
module calendar_date_day_arithmetic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [3:0]  month_i,
  input  logic [5:0]  day_i,
  input  logic [13:0] year_i,
  input  logic [22:0] offset_i,
  input  logic [3:0]  other_month_i,
  input  logic [4:0]  other_day_i,
  input  logic [13:0] other_year_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic [13:0] out_year_o,
  output logic [22:0] julian_day_o,
  output logic [8:0]  year_day_o,
  output logic [2:0]  weekday_o,
  output logic [22:0] days_between_o,
  output logic        out_of_range_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i
);
  import cdda_pkg::*;

  step_e    state_q, state_d;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     adv;
  logic     in_xfer;

  logic [3:0]  dflt_m_q;
  logic [4:0]  dflt_d_q;
  logic [13:0] dflt_y_q;
  logic [3:0]  cm_q;
  logic [4:0]  cd_q;
  logic [13:0] cy_q;
  logic [22:0] off_q;
  logic [3:0]  om_q;
  logic [4:0]  od_q;
  logic [13:0] oy_q;

  logic signed [25:0] njd_q;
  logic [22:0] l_q;
  logic [7:0]  n_q;
  logic [16:0] l2_q;
  logic [6:0]  i_q;
  logic [16:0] l3_q;
  logic [3:0]  j_q;
  logic [23:0] jd_q;
  logic [23:0] ojd_q;
  logic [2:0]  wd_q;
  logic [22:0] diff_q;
  logic [8:0]  yday_q;
  logic        flag_q;

  logic [23:0] jd_now;
  logic signed [24:0] diff_full;
  logic [24:0] nmul;
  logic [22:0] l_new;
  logic        lq;
  logic        leap;

  assign in_xfer     = in_valid_i && in_ready_o;
  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = state_q == ST_OUT;
  assign cfg_ready_o = 1'b1;
  assign adv         = !div_rsp.busy;

  assign jd_now    = jd_calc(cm_q, cd_q, cy_q, div_rsp.quot[14:0]);
  assign diff_full = $signed({1'b0, ojd_q}) - $signed({1'b0, jd_q});
  assign nmul      = 25'(div_rsp.quot[7:0]) * 25'd146097 + 25'd3;
  assign l_new     = njd_q[22:0] + 23'd68569;
  assign lq        = j_q >= 4'd11;
  assign leap      = (cy_q[1:0] == 2'b00 && div_rsp.rem != '0) ||
                     (div_rsp.rem == '0 && div_rsp.quot[1:0] == 2'b00);

  cdda_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer: each step waits for the divider, uses its result and
  // possibly starts the next division.
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = mode_i ? ST_P0 : ST_F0;
      end
      ST_P0: begin
        if (adv) begin
          div_req.start    = 1'b1;
          div_req.dividend = DvdW'(century_arg(cm_q, cy_q));
          div_req.divisor  = DsrW'(100);
          state_d          = ST_P1;
        end
      end
      ST_P1: if (adv) state_d = ST_P2;
      ST_P2: begin
        if (adv) begin
          if (njd_q < JdFirst || njd_q > JdLast) begin
            state_d = ST_F0;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DvdW'({l_new, 2'b00});
            div_req.divisor  = DsrW'(146097);
            state_d          = ST_P3;
          end
        end
      end
      ST_P3: if (adv) state_d = ST_P4;
      ST_P4: begin
        if (adv) begin
          div_req.start    = 1'b1;
          div_req.dividend = DvdW'(28'(l2_q + 17'd1) * 28'd4000);
          div_req.divisor  = DsrW'(1461001);
          state_d          = ST_P5;
        end
      end
      ST_P5: if (adv) state_d = ST_P6;
      ST_P6: begin
        if (adv) begin
          div_req.start    = 1'b1;
          div_req.dividend = DvdW'(28'(l3_q) * 28'd80);
          div_req.divisor  = DsrW'(2447);
          state_d          = ST_P7;
        end
      end
      ST_P7: begin
        if (adv) begin
          div_req.start    = 1'b1;
          div_req.dividend = DvdW'(28'(div_rsp.quot[3:0]) * 28'd2447);
          div_req.divisor  = DsrW'(80);
          state_d          = ST_P8;
        end
      end
      ST_P8: if (adv) state_d = ST_F0;
      ST_F0: begin
        if (adv) begin
          div_req.start    = 1'b1;
          div_req.dividend = DvdW'(century_arg(cm_q, cy_q));
          div_req.divisor  = DsrW'(100);
          state_d          = ST_F1;
        end
      end
      ST_F1: if (adv) state_d = ST_F2;
      ST_F2: begin
        if (adv) begin
          div_req.start    = 1'b1;
          div_req.dividend = DvdW'(jd_q);
          div_req.divisor  = DsrW'(7);
          state_d          = ST_F3;
        end
      end
      ST_F3: begin
        if (adv) begin
          div_req.start    = 1'b1;
          div_req.dividend = DvdW'(century_arg(om_q, oy_q));
          div_req.divisor  = DsrW'(100);
          state_d          = ST_F4;
        end
      end
      ST_F4: if (adv) state_d = ST_F5;
      ST_F5: begin
        if (adv) begin
          div_req.start    = 1'b1;
          div_req.dividend = DvdW'(cy_q);
          div_req.divisor  = DsrW'(100);
          state_d          = ST_F6;
        end
      end
      ST_F6: if (adv) state_d = ST_OUT;
      ST_OUT: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_m_q <= RstMonth;
      dflt_d_q <= RstDay;
      dflt_y_q <= RstYear;
      cm_q     <= RstMonth;
      cd_q     <= RstDay;
      cy_q     <= RstYear;
      flag_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgMonth: dflt_m_q <= cfg_data_i[3:0];
          CfgDay:   dflt_d_q <= cfg_data_i[4:0];
          CfgYear:  dflt_y_q <= cfg_data_i;
          default:  ;
        endcase
      end
      if (in_xfer) begin
        flag_q <= 1'b0;
        if (!mode_i) begin
          // A month above 12 or a day above 31 falls back to the default date.
          if (month_i > 4'd12 || day_i > 6'd31) begin
            cm_q <= dflt_m_q;
            cd_q <= dflt_d_q;
            cy_q <= dflt_y_q;
          end else begin
            cm_q <= month_i;
            cd_q <= day_i[4:0];
            cy_q <= year_i;
          end
        end
      end
      if (state_q == ST_P2 && adv && (njd_q < JdFirst || njd_q > JdLast)) begin
        flag_q <= 1'b1;
      end
      if (state_q == ST_P8 && adv) begin
        cm_q <= 4'(j_q + 4'd2 - (lq ? 4'd12 : 4'd0));
        cd_q <= 5'(l3_q - 17'(div_rsp.quot));
        cy_q <= 14'(16'(n_q) * 16'd100 - 16'd4900 + 16'(i_q) + 16'(lq));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      off_q <= offset_i;
      om_q  <= other_month_i;
      od_q  <= other_day_i;
      oy_q  <= other_year_i;
    end
    if (adv) begin
      case (state_q)
        ST_P1: njd_q <= $signed({2'b00, jd_now}) + $signed({{3{off_q[22]}}, off_q});
        ST_P2: l_q   <= l_new;
        ST_P3: begin
          n_q  <= div_rsp.quot[7:0];
          l2_q <= 17'(25'(l_q) - 25'((25'(div_rsp.quot[7:0]) * 25'd146097 + 25'd3) >> 2));
        end
        ST_P5: begin
          i_q  <= div_rsp.quot[6:0];
          l3_q <= 17'(l2_q - 17'((18'(div_rsp.quot[6:0]) * 18'd1461) >> 2) + 17'd31);
        end
        ST_P7: j_q <= div_rsp.quot[3:0];
        ST_F1: jd_q <= jd_now;
        ST_F3: wd_q <= div_rsp.rem[2:0];
        ST_F4: ojd_q <= jd_calc(om_q, od_q, oy_q, div_rsp.quot[14:0]);
        ST_F5: begin
          if (diff_full > 25'sd4194303) begin
            diff_q <= 23'h3FFFFF;
          end else if (diff_full < -25'sd4194304) begin
            diff_q <= 23'h400000;
          end else begin
            diff_q <= diff_full[22:0];
          end
        end
        ST_F6: begin
          if (cm_q < 4'd1 || cm_q > 4'd12) begin
            yday_q <= 9'd0;
          end else begin
            yday_q <= days_before(cm_q) + 9'(cd_q) + 9'(leap && cm_q > 4'd2);
          end
        end
        default: ;
      endcase
    end
  end

  // nmul mirrors the P3 product for the range assertion below.
  assign out_month_o    = cm_q;
  assign out_day_o      = cd_q;
  assign out_year_o     = cy_q;
  assign julian_day_o   = jd_q[22:0];
  assign year_day_o     = yday_q;
  assign weekday_o      = wd_q;
  assign days_between_o = diff_q;
  assign out_of_range_o = flag_q;

`ifndef ASSERT_OFF
  a_ready_vs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result waits");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> weekday_o <= 3'd6)
    else $error("weekday out of range");

  a_load_no_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !mode_i) |=> !out_of_range_o)
    else $error("load raised the range flag");

  a_century_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_P3 && adv) |-> (25'(l_q) >= (nmul >> 2)))
    else $error("400-year fold underflowed");
`endif

endmodule
